// ----- sv/binary_min_heap_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Binary min-heap queue assertion macros
// Shared concurrent-assertion shorthands for the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- sv/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Entry type, operation and status codes, sequencer states and compare codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

	localparam int PRIO_W = 8;
	localparam int TAG_W  = 16;
	localparam int HELD_W = 7;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [0:0] {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_EX_LOAD,
		ST_DN_CHK,
		ST_DN_CMP,
		ST_DONE
	} fsm_t;

	// Winner of one compare step: the current entry or one of two candidates.
	typedef enum logic [1:0] {
		PICK_CUR,
		PICK_A,
		PICK_B
	} pick_t;

endpackage

`default_nettype wire

// ----- sv/bmhq_store.sv -----
// ----------------------------------------------------------------------------
// Heap slot store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_store
	import bmhq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output entry_t             rdata_a,
	output entry_t             rdata_b
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ----- sv/bmhq_pick.sv -----
// ----------------------------------------------------------------------------
// Heap compare unit
// Pick the smallest priority of a current entry and up to two candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_pick
	import bmhq_pkg::*;
(
	input  wire entry_t cur,
	input  wire entry_t cand_a,
	input  wire logic   a_ok,
	input  wire entry_t cand_b,
	input  wire logic   b_ok,
	output pick_t       sel
);

	logic [PRIO_W-1:0] best_a;

	// Strict less-than at each step, candidate A first: ties keep the earlier one.
	always_comb begin
		best_a = cur.prio;
		sel    = PICK_CUR;
		if (a_ok && (cand_a.prio < cur.prio)) begin
			best_a = cand_a.prio;
			sel    = PICK_A;
		end
		if (b_ok && (cand_b.prio < best_a)) begin
			sel = PICK_B;
		end
	end

endmodule

`default_nettype wire

// ----- sv/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Array heap in a two-read one-write slot store, walked by a small sequencer
// that reuses one compare unit for every sift-up and sift-down level.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tuser: opcode | tdata: priority_req[7:0], payload_tag[23:8]
// m_axis    out  tuser: status | tdata: out_priority[7:0], out_tag[23:8],
//                                       entries_held[30:24], is_empty[31]
//
// An insert takes a parent check and a parent compare per level it rises and
// stops at the root or when the parent compare keeps the parent; an extract
// loads the root and last entry, then takes a child check and a child compare
// per level it sinks and stops at a leaf or when the compare keeps the moving
// entry, skipping the sift when it takes the last entry. An extract sinking to
// the deepest leaf is slowest; full-insert and empty-extract go to ST_DONE.
// Reset clears the entry count and the sequencer; the slot store is not cleared.
// s_axis_tready is high only while the sequencer is idle. A finished result
// waits in the output register under back-pressure, and the next operation
// may already be accepted and worked on meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // priority_req[7:0], payload_tag[23:8]
	input  wire logic [0:0]  s_axis_tuser,  // opcode[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // out_priority[7:0], out_tag[23:8],
	                                        // entries_held[30:24], is_empty[31]
	output logic [1:0]       m_axis_tuser   // status[1:0]
);

	localparam int AW = $clog2(CAPACITY);      // slot index
	localparam int CW = $clog2(CAPACITY + 1);  // entry count, holds CAPACITY itself
	localparam int IW = AW + 2;                // child index, may run past the end

	// Sequencer and working registers
	fsm_t              state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     pos_q;       // hole being filled by the moving entry
	entry_t            v_q;         // entry being sifted
	stat_t             res_status_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic [TAG_W-1:0]  res_tag_q;

	// Output register
	logic              m_valid_q;
	stat_t             m_status_q;
	logic [PRIO_W-1:0] m_prio_q;
	logic [TAG_W-1:0]  m_tag_q;
	logic [HELD_W-1:0] m_held_q;
	logic              m_empty_q;

	// Store and compare unit hookup
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic [AW-1:0]     rd_addr_a, rd_addr_b;
	entry_t            rd_data_a, rd_data_b;
	entry_t            pk_cur, pk_a, pk_b;
	logic              pk_a_ok, pk_b_ok;
	pick_t             pk_sel;

	// Index arithmetic
	logic              in_xfer, out_free, is_full, ex_start;
	op_t               in_op;
	entry_t            in_entry;
	logic [AW-1:0]     parent_idx;
	logic [IW-1:0]     left_idx, right_idx, n_ext;
	logic [CW-1:0]     cnt_m1;
	logic              left_in, right_in;

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign in_op      = op_t'(s_axis_tuser);
	assign in_entry   = '{tag: s_axis_tdata[23:8], prio: s_axis_tdata[7:0]};
	assign is_full    = (count_q == CW'(CAPACITY));
	assign ex_start   = in_xfer && (in_op == OP_EXTRACT) && (count_q != '0);
	assign cnt_m1     = count_q - CW'(1);
	assign parent_idx = (pos_q - AW'(1)) >> 1;
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = {1'b0, pos_q, 1'b0} + IW'(2);
	assign n_ext      = IW'(count_q);
	assign left_in    = left_idx < n_ext;
	assign right_in   = right_idx < n_ext;

	bmhq_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rd_data_a),
		.rdata_b (rd_data_b)
	);

	bmhq_pick u_pick (
		.cur    (pk_cur),
		.cand_a (pk_a),
		.a_ok   (pk_a_ok),
		.cand_b (pk_b),
		.b_ok   (pk_b_ok),
		.sel    (pk_sel)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_op == OP_INSERT) begin
						state_d = is_full ? ST_DONE : ST_UP_CHK;
					end else begin
						state_d = (count_q == '0) ? ST_DONE : ST_EX_LOAD;
					end
				end
			end
			ST_UP_CHK: begin
				state_d = (pos_q == '0) ? ST_DONE : ST_UP_CMP;
			end
			ST_UP_CMP: begin
				state_d = (pk_sel == PICK_A) ? ST_UP_CHK : ST_DONE;
			end
			ST_EX_LOAD: begin
				state_d = (count_q == '0) ? ST_DONE : ST_DN_CHK;
			end
			ST_DN_CHK: begin
				state_d = left_in ? ST_DN_CMP : ST_DONE;
			end
			ST_DN_CMP: begin
				state_d = (pk_sel == PICK_CUR) ? ST_DONE : ST_DN_CHK;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: store ports and compare unit operands
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		wr_addr       = pos_q;
		wr_data       = v_q;
		rd_addr_a     = '0;
		rd_addr_b     = cnt_m1[AW-1:0];
		pk_cur        = v_q;
		pk_a          = rd_data_a;
		pk_a_ok       = 1'b0;
		pk_b          = rd_data_b;
		pk_b_ok       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// Root and last slot are fetched here for a possible extract.
				s_axis_tready = 1'b1;
			end
			ST_UP_CHK: begin
				rd_addr_a = parent_idx;
				mem_we    = (pos_q == '0);
			end
			ST_UP_CMP: begin
				// Moving entry wins over the parent only on a strictly lower priority.
				pk_cur  = rd_data_a;
				pk_a    = v_q;
				pk_a_ok = 1'b1;
				mem_we  = 1'b1;
				wr_data = (pk_sel == PICK_A) ? rd_data_a : v_q;
			end
			ST_EX_LOAD: begin
			end
			ST_DN_CHK: begin
				rd_addr_a = left_idx[AW-1:0];
				rd_addr_b = right_idx[AW-1:0];
				mem_we    = !left_in;
			end
			ST_DN_CMP: begin
				pk_a_ok = 1'b1;
				pk_b_ok = right_in;
				mem_we  = 1'b1;
				case (pk_sel)
					PICK_A:  wr_data = rd_data_a;
					PICK_B:  wr_data = rd_data_b;
					default: wr_data = v_q;
				endcase
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				if (in_op == OP_INSERT && !is_full) begin
					count_q <= count_q + CW'(1);
				end else if (in_op == OP_EXTRACT && count_q != '0) begin
					count_q <= cnt_m1;
				end
			end
		end
	end

	// Working registers: capture the operation, then advance the hole
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					v_q        <= in_entry;
					pos_q      <= count_q[AW-1:0];
					res_prio_q <= '0;
					res_tag_q  <= '0;
					if (in_op == OP_INSERT) begin
						res_status_q <= is_full ? STAT_FULL : STAT_OK;
					end else begin
						res_status_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
					end
				end
			end
			ST_UP_CMP: begin
				if (pk_sel == PICK_A) begin
					pos_q <= parent_idx;
				end
			end
			ST_EX_LOAD: begin
				// Hand out the root; the last entry restarts from the root.
				res_prio_q <= rd_data_a.prio;
				res_tag_q  <= rd_data_a.tag;
				v_q        <= rd_data_b;
				pos_q      <= '0;
			end
			ST_DN_CMP: begin
				if (pk_sel == PICK_A) begin
					pos_q <= left_idx[AW-1:0];
				end else if (pk_sel == PICK_B) begin
					pos_q <= right_idx[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load when the result is ready and the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_prio_q   <= res_prio_q;
			m_tag_q    <= res_tag_q;
			m_held_q   <= HELD_W'(count_q);
			m_empty_q  <= (count_q == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {m_empty_q, m_held_q, m_tag_q, m_prio_q};

	`BMHQ_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count overflow")
	`BMHQ_ASSERT_IMP(a_write_live, clk, arst_n, mem_we, CW'(wr_addr) < count_q, "dead slot write")
	`BMHQ_ASSERT_IMP(a_down_pos, clk, arst_n, state_q == ST_DN_CHK, CW'(pos_q) < count_q, "bad hole")
	`BMHQ_ASSERT_NXT(a_extract_go, clk, arst_n, ex_start, state_q == ST_EX_LOAD, "no extract")
	`BMHQ_ASSERT_IMP(a_load_done, clk, arst_n, $rose(m_valid_q), $past(state_q) == ST_DONE, "early load")

endmodule

`default_nettype wire
